// ===== hdl/mcstm_pkg.sv =====
// ---------------------------------------------------------------------------
// Multi-cell subframe tick master: shared types and constants
// Command and result beat layouts, operation codes and sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcstm_pkg;

	localparam int CNT_W   = 32;
	localparam int TICK_W  = 14;
	localparam int OP_W    = 2;
	localparam int CELL_W  = 4;
	localparam int FRAME_W = 10;
	localparam int SUB_W   = 4;

	localparam logic [OP_W-1:0] OP_ACTIVATE   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEACTIVATE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK       = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [CELL_W-1:0]  cell_req;
		logic [FRAME_W-1:0] frame_number;
		logic [SUB_W-1:0]   subframe_number;
	} cmd_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic              is_master;
		logic [CNT_W-1:0]  cell_counter;
		logic              all_removed;
		logic              error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/mcstm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcstm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mcstm_mod.sv =====
// ---------------------------------------------------------------------------
// Remainder by a constant
// Reciprocal-multiply remainder of a 32-bit counter by the hyperframe
// length; done pulses when rem is final.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcstm_mod #(
	parameter int DIVISOR = 10240
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mcstm_pkg::CNT_W-1:0]  dividend,
	output logic                              done,
	output logic [$clog2(DIVISOR)-1:0]        rem
);

	localparam int NW    = mcstm_pkg::CNT_W;
	localparam int RW    = $clog2(DIVISOR);
	// scale keeps the reciprocal below 2^32 and the quotient estimate at most one low
	localparam int SHIFT = NW - 1 + RW;
	localparam logic [2*NW-1:0] RECIP_W = ((2*NW)'(1) << SHIFT) / (2*NW)'(DIVISOR);
	localparam logic [NW-1:0]   RECIP   = RECIP_W[NW-1:0];
	localparam logic [NW-1:0]   DIV_V   = NW'(DIVISOR);
	localparam logic [RW:0]     DIV_R   = (RW+1)'(DIVISOR);

	logic [NW-1:0]   dv_s1;
	logic [2*NW-1:0] prod_s1;
	logic            vld_s1;
	logic [RW:0]     part_s2;
	logic            vld_s2;
	logic [RW-1:0]   rem_q;
	logic            done_q;
	logic [NW-1:0]   quo_est;
	logic [NW-1:0]   quo_mul;
	logic [NW-1:0]   part_full;

	assign quo_est   = NW'(prod_s1 >> SHIFT);
	assign quo_mul   = quo_est * DIV_V;
	// below twice the divisor, so one conditional subtract finishes it
	assign part_full = dv_s1 - quo_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_s1   <= dividend;
			prod_s1 <= (2*NW)'(dividend) * (2*NW)'(RECIP);
		end
		if (vld_s1) begin
			part_s2 <= part_full[RW:0];
		end
		if (vld_s2) begin
			rem_q <= (part_s2 >= DIV_R) ? RW'(part_s2 - DIV_R) : part_s2[RW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== hdl/multi_cell_subframe_tick_master.sv =====
// ---------------------------------------------------------------------------
// Multi-cell subframe tick master
//
//   channel | ports                 | handshake
//   --------+-----------------------+-------------------------------------
//   command | cmd (cmd_t)           | taken when start is high, busy low
//   result  | result (result_t)     | valid one cycle while done is high
//
// Errors and activation of the first cell finish in the execute state;
// a deactivation walks the active list from the head, one link RAM
// read per list step, until it reaches the cell; activation into a
// non-empty list and slot ticks wait on the reciprocal remainder units
// that find the hyperframe base of the cell and master counters.
// Reset clears the active marks, counter valid bits, list head and master
// counter; the RAMs need no clearing pass. The receiver cannot stall: a
// result is shown for one cycle and busy drops in that same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_cell_subframe_tick_master #(
	parameter int MAX_CELLS           = 16,
	parameter int FRAMES_PER_HYPER    = 1024,
	parameter int SUBFRAMES_PER_FRAME = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire mcstm_pkg::cmd_t    cmd,
	output logic                    busy,
	output logic                    done,
	output mcstm_pkg::result_t      result
);

	localparam int CW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int HYPER_INT = FRAMES_PER_HYPER * SUBFRAMES_PER_FRAME;
	localparam int RW        = $clog2(HYPER_INT);
	localparam int NW        = mcstm_pkg::CNT_W;
	localparam int TW        = mcstm_pkg::TICK_W;

	localparam logic [NW-1:0]        HYPER_LEN  = NW'(HYPER_INT);
	localparam logic [NW-1:0]        HALF_HYPER = NW'(HYPER_INT / 2);
	localparam logic [NW-1:0]        HYPER_M1   = HYPER_LEN - NW'(1);
	localparam logic [NW-1:0]        ALL_ONES   = '1;
	localparam logic signed [NW-1:0] NEG_HYPER  = $signed(NW'(0) - HYPER_LEN);
	localparam logic signed [NW-1:0] NEG_HALF   = $signed(NW'(0) - HALF_HYPER);
	localparam logic signed [NW-1:0] POS_HALF   = $signed(HALF_HYPER);
	localparam logic [CW:0]          LINK_EMPTY = {1'b1, {CW{1'b0}}};

	mcstm_pkg::state_t  state_q, state_d;
	mcstm_pkg::cmd_t    req_q, req_d;
	mcstm_pkg::result_t result_q, result_d;
	logic               done_q, done_d;

	logic [MAX_CELLS-1:0] act_q, act_d;
	logic [MAX_CELLS-1:0] cnt_vld_q, cnt_vld_d;
	logic                 head_vld_q, head_vld_d;
	logic [CW-1:0]        head_q, head_d;
	logic [CW-1:0]        tail_q, tail_d;
	logic [CW-1:0]        cur_q, cur_d;
	logic [CW-1:0]        prev_q, prev_d;
	logic                 prev_vld_q, prev_vld_d;
	logic [NW-1:0]        master_q, master_d;
	logic [NW-1:0]        cur_a_q, cur_a_d;
	logic [NW-1:0]        cur_b_q, cur_b_d;

	logic          cnt_we;
	logic [NW-1:0] cnt_wdata;
	logic [NW-1:0] cnt_rdata;
	logic          link_we;
	logic [CW-1:0] link_waddr;
	logic [CW:0]   link_wdata;
	logic [CW:0]   link_rdata;

	logic          mod_start;
	logic          done_a, done_b;
	logic [RW-1:0] rem_a, rem_b;

	logic [CW-1:0] idx;
	logic          bad;
	logic          head_hit;
	logic [NW-1:0] pos;
	logic [NW-1:0] cnt_rd;
	logic [NW-1:0] d_b;
	logic          act_wrap;
	logic [NW-1:0] act_newc;
	logic [NW-1:0] tick_newc;
	logic          resync;
	logic          behind;
	logic [NW-1:0] tick_master;
	logic [TW-1:0] tick_ticks;

	assign idx      = CW'(req_q.cell_req);
	assign bad      = (32'(req_q.cell_req) >= 32'(MAX_CELLS)) ||
	                  !(req_q.operation == mcstm_pkg::OP_ACTIVATE ||
	                    req_q.operation == mcstm_pkg::OP_DEACTIVATE ||
	                    req_q.operation == mcstm_pkg::OP_TICK);
	assign head_hit = head_vld_q && (head_q == idx);
	assign pos      = NW'(req_q.frame_number) * NW'(SUBFRAMES_PER_FRAME) +
	                  NW'(req_q.subframe_number);
	assign cnt_rd   = cnt_vld_q[idx] ? cnt_rdata : '0;

	// activation into a non-empty list: rebased slot minus one, plus a hyperframe on a wrap
	assign d_b      = cur_b_q - master_q;
	assign act_wrap = $signed(d_b) < NEG_HALF;
	assign act_newc = cur_b_q + (act_wrap ? HYPER_M1 : ALL_ONES);

	// slot tick: cell counter never runs backwards
	assign tick_newc = cur_a_q + ((cur_a_q < cnt_rd) ? HYPER_LEN : '0);

	// master tick: resync on a large jump, else wrap a small backward step
	assign resync      = ($signed(d_b) < NEG_HYPER) || ($signed(d_b) > POS_HALF);
	assign behind      = d_b[NW-1];
	assign tick_master = (!resync && behind) ? cur_b_q + HYPER_LEN : cur_b_q;
	assign tick_ticks  = resync ? TW'(1) :
	                     behind ? d_b[TW-1:0] + HYPER_LEN[TW-1:0] : d_b[TW-1:0];

	mcstm_ram #(
		.WIDTH (NW),
		.DEPTH (MAX_CELLS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (idx),
		.wdata (cnt_wdata),
		.raddr (idx),
		.rdata (cnt_rdata)
	);

	mcstm_ram #(
		.WIDTH (CW + 1),
		.DEPTH (MAX_CELLS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_q),
		.rdata (link_rdata)
	);

	mcstm_mod #(
		.DIVISOR (HYPER_INT)
	) u_mod_cell (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cnt_rd),
		.done     (done_a),
		.rem      (rem_a)
	);

	mcstm_mod #(
		.DIVISOR (HYPER_INT)
	) u_mod_master (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (master_q),
		.done     (done_b),
		.rem      (rem_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mcstm_pkg::ST_IDLE;
			done_q     <= 1'b0;
			act_q      <= '0;
			cnt_vld_q  <= '0;
			head_vld_q <= 1'b0;
			prev_vld_q <= 1'b0;
			master_q   <= '0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			act_q      <= act_d;
			cnt_vld_q  <= cnt_vld_d;
			head_vld_q <= head_vld_d;
			prev_vld_q <= prev_vld_d;
			master_q   <= master_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		result_q <= result_d;
		head_q   <= head_d;
		tail_q   <= tail_d;
		cur_q    <= cur_d;
		prev_q   <= prev_d;
		cur_a_q  <= cur_a_d;
		cur_b_q  <= cur_b_d;
	end

	always_comb begin
		mcstm_pkg::result_t res;
		logic               finish;

		res        = '0;
		finish     = 1'b0;
		state_d    = state_q;
		req_d      = req_q;
		result_d   = result_q;
		done_d     = 1'b0;
		act_d      = act_q;
		cnt_vld_d  = cnt_vld_q;
		head_vld_d = head_vld_q;
		head_d     = head_q;
		tail_d     = tail_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		prev_vld_d = prev_vld_q;
		master_d   = master_q;
		cur_a_d    = cur_a_q;
		cur_b_d    = cur_b_q;
		cnt_we     = 1'b0;
		cnt_wdata  = tick_newc;
		link_we    = 1'b0;
		link_waddr = idx;
		link_wdata = LINK_EMPTY;
		mod_start  = 1'b0;

		unique case (state_q)
			mcstm_pkg::ST_IDLE: begin
				if (start) begin
					req_d   = cmd;
					state_d = mcstm_pkg::ST_FETCH;
				end
			end
			mcstm_pkg::ST_FETCH: begin
				state_d = mcstm_pkg::ST_EXEC;
			end
			mcstm_pkg::ST_EXEC: begin
				if (bad) begin
					res.error = 1'b1;
					finish    = 1'b1;
				end else begin
					case (req_q.operation)
						mcstm_pkg::OP_ACTIVATE: begin
							if (act_q[idx]) begin
								res.error        = 1'b1;
								res.is_master    = head_hit;
								res.cell_counter = cnt_rd;
								finish           = 1'b1;
							end else if (!head_vld_q) begin
								// first cell becomes master; its own counter stays
								act_d[idx]       = 1'b1;
								head_vld_d       = 1'b1;
								head_d           = idx;
								tail_d           = idx;
								master_d         = pos - NW'(1);
								link_we          = 1'b1;
								res.is_master    = 1'b1;
								res.cell_counter = cnt_rd;
								finish           = 1'b1;
							end else begin
								// hook the new cell behind the tail
								link_we    = 1'b1;
								link_waddr = tail_q;
								link_wdata = {1'b0, idx};
								mod_start  = 1'b1;
								state_d    = mcstm_pkg::ST_DIV;
							end
						end
						mcstm_pkg::OP_DEACTIVATE: begin
							if (!act_q[idx]) begin
								res.error        = 1'b1;
								res.is_master    = head_hit;
								res.cell_counter = cnt_rd;
								finish           = 1'b1;
							end else begin
								cur_d      = head_q;
								prev_vld_d = 1'b0;
								state_d    = mcstm_pkg::ST_WALK_RD;
							end
						end
						mcstm_pkg::OP_TICK: begin
							mod_start = 1'b1;
							state_d   = mcstm_pkg::ST_DIV;
						end
						default: begin
							res.error = 1'b1;
							finish    = 1'b1;
						end
					endcase
				end
			end
			mcstm_pkg::ST_WALK_RD: begin
				state_d = mcstm_pkg::ST_WALK_CHK;
			end
			mcstm_pkg::ST_WALK_CHK: begin
				if (cur_q == idx) begin
					// unlink: bypass the cell from its predecessor or the head
					act_d[idx] = 1'b0;
					if (!prev_vld_q) begin
						head_vld_d      = !link_rdata[CW];
						head_d          = link_rdata[CW-1:0];
						res.all_removed = link_rdata[CW];
					end else begin
						link_we    = 1'b1;
						link_waddr = prev_q;
						link_wdata = link_rdata;
						if (tail_q == idx) begin
							tail_d = prev_q;
						end
					end
					res.cell_counter = cnt_rd;
					finish           = 1'b1;
				end else begin
					prev_d     = cur_q;
					prev_vld_d = 1'b1;
					cur_d      = link_rdata[CW-1:0];
					state_d    = mcstm_pkg::ST_WALK_RD;
				end
			end
			mcstm_pkg::ST_DIV: begin
				// rebase both counters to the start of their hyperframe
				if (done_a && done_b) begin
					cur_a_d = cnt_rd - NW'(rem_a) + pos;
					cur_b_d = master_q - NW'(rem_b) + pos;
					state_d = mcstm_pkg::ST_FIN;
				end
			end
			mcstm_pkg::ST_FIN: begin
				case (req_q.operation)
					mcstm_pkg::OP_ACTIVATE: begin
						cnt_we           = 1'b1;
						cnt_wdata        = act_newc;
						cnt_vld_d[idx]   = 1'b1;
						act_d[idx]       = 1'b1;
						tail_d           = idx;
						link_we          = 1'b1;
						res.cell_counter = act_newc;
					end
					mcstm_pkg::OP_TICK: begin
						cnt_we         = 1'b1;
						cnt_wdata      = tick_newc;
						cnt_vld_d[idx] = 1'b1;
						if (head_hit) begin
							master_d       = tick_master;
							res.tick_count = tick_ticks;
						end
						res.is_master    = head_hit;
						res.cell_counter = tick_newc;
					end
					default: begin
						res.error = 1'b1;
					end
				endcase
				finish = 1'b1;
			end
			default: begin
				state_d = mcstm_pkg::ST_IDLE;
			end
		endcase

		if (finish) begin
			result_d = res;
			done_d   = 1'b1;
			state_d  = mcstm_pkg::ST_IDLE;
		end
	end

	assign busy   = (state_q != mcstm_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
